[design/srs_pkg.sv]
// Shared types and constants for the sorted key/value row store.
// No dependencies; imported by srs_cell and sorted_key_value_row_store.
package srs_pkg;

	localparam int CAPACITY_DEF = 64;
	localparam int KEY_W        = 32;
	localparam int VAL_W        = 64;

	typedef enum logic [2:0] {
		CMD_INSERT  = 3'd0,
		CMD_REMOVE  = 3'd1,
		CMD_LOOKUP  = 3'd2,
		CMD_ACCUM   = 3'd3,
		CMD_WRITE   = 3'd4,
		CMD_READ    = 3'd5,
		CMD_NOP6    = 3'd6,
		CMD_NOP7    = 3'd7
	} srs_cmd_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_MISSING = 2'd1,
		ST_FULL    = 2'd2,
		ST_RANGE   = 2'd3
	} srs_status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CMP,
		S_SEARCH,
		S_FETCH,
		S_APPLY
	} srs_state_t;

	typedef struct packed {
		logic cmp;
		logic ins;
		logic rem;
		logic wr;
	} srs_cell_ctrl_t;

endpackage

[design/srs_cell.sv]
// One entry of the sorted row: holds a key and a value, compares against the
// broadcast key and shifts to or from its neighbors. Depends on srs_pkg.
module srs_cell import srs_pkg::*; #(
	parameter int INDEX = 0,
	parameter int AW    = 6,
	parameter int CW    = 7
) (
	input  logic             clk,
	input  srs_cell_ctrl_t   ctrl,
	input  logic [KEY_W-1:0] key,
	input  logic [VAL_W-1:0] wdata,
	input  logic [CW-1:0]    count,
	input  logic [AW-1:0]    idx,
	input  logic [KEY_W-1:0] prev_key,
	input  logic [VAL_W-1:0] prev_value,
	input  logic             prev_lt,
	input  logic [KEY_W-1:0] next_key,
	input  logic [VAL_W-1:0] next_value,
	output logic [KEY_W-1:0] cur_key,
	output logic [VAL_W-1:0] cur_value,
	output logic             lt,
	output logic             gt,
	output logic             ins_here,
	output logic [KEY_W-1:0] rd_key,
	output logic [VAL_W-1:0] rd_value
);

	logic [KEY_W-1:0] key_q;
	logic [VAL_W-1:0] val_q;
	logic             lt_q;
	logic             gt_q;
	logic             valid;
	logic             sel;
	logic             shift_up;
	logic             shift_down;

	assign valid      = CW'(INDEX) < count;
	assign sel        = AW'(INDEX) == idx;
	assign ins_here   = !lt_q && prev_lt;
	assign shift_up   = !lt_q && !prev_lt && (CW'(INDEX) <= count);
	assign shift_down = (AW'(INDEX) >= idx) && (CW'(INDEX + 1) < count);

	always_ff @(posedge clk) begin
		if (ctrl.cmp) begin
			lt_q <= valid && (key_q < key);
			gt_q <= valid && (key_q > key);
		end
		if (ctrl.ins) begin
			if (ins_here) begin
				key_q <= key;
				val_q <= wdata;
			end else if (shift_up) begin
				key_q <= prev_key;
				val_q <= prev_value;
			end
		end else if (ctrl.rem) begin
			if (shift_down) begin
				key_q <= next_key;
				val_q <= next_value;
			end
		end else if (ctrl.wr && sel) begin
			val_q <= wdata;
		end
	end

	assign cur_key   = key_q;
	assign cur_value = val_q;
	assign lt        = lt_q;
	assign gt        = gt_q;
	assign rd_key    = sel ? key_q : '0;
	assign rd_value  = sel ? val_q : '0;

endmodule

[design/sorted_key_value_row_store.sv]
// Top level of the sorted key/value row store: sequencer, binary search and
// the row of srs_cell entries. Depends on srs_pkg and srs_cell.
//
// Holds up to CAPACITY entries sorted by ascending unsigned key, each with a
// signed Q32.32 value. A command is taken when start is high and busy is low;
// its one result appears on the result ports for a single cycle with done
// high, and the receiver must take it then, as there is no way to stall it.
// All cells compare their keys against the command key at once, so insert
// passes through a compare state and an apply state that shifts the row.
// Remove, lookup, accumulate and overwrite pass a compare state, then one
// binary-search step per cycle over the registered compare flags (on a miss
// the last step finds the range empty), then a fetch state when the key is
// found and an apply state. Read at position passes a fetch and an apply
// state; out of range, and for commands six and seven, only the apply state.
// A new command can be taken in the cycle that shows the previous result.
module sorted_key_value_row_store import srs_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic [2:0]              command,
	input  logic [KEY_W-1:0]        key,
	input  logic signed [VAL_W-1:0] value,
	input  logic [5:0]              position,
	output logic                    done,
	output logic [1:0]              status,
	output logic [5:0]              slot,
	output logic [KEY_W-1:0]        key_out,
	output logic signed [VAL_W-1:0] value_out,
	output logic [6:0]              entry_total
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	srs_state_t       state_q, state_d;
	srs_cmd_t         cmd_q;
	logic [KEY_W-1:0] key_q;
	logic [VAL_W-1:0] val_q;
	logic [CW-1:0]    count_q;
	logic [CW-1:0]    lo_q;
	logic [CW-1:0]    hx_q;
	logic [AW-1:0]    idx_q;
	logic             miss_q;
	logic [KEY_W-1:0] rd_key_q;
	logic [VAL_W-1:0] rd_val_q;

	logic             done_q;
	logic [1:0]       status_q;
	logic [5:0]       slot_q;
	logic [KEY_W-1:0] key_out_q;
	logic [VAL_W-1:0] value_out_q;

	srs_cell_ctrl_t   ctrl;
	logic [VAL_W-1:0] wdata;
	logic [KEY_W-1:0] cell_key [CAPACITY];
	logic [VAL_W-1:0] cell_val [CAPACITY];
	logic [KEY_W-1:0] cell_rk [CAPACITY];
	logic [VAL_W-1:0] cell_rv [CAPACITY];
	logic [CAPACITY-1:0] lt_vec;
	logic [CAPACITY-1:0] gt_vec;
	logic [CAPACITY-1:0] ins_vec;

	logic             accept;
	logic             pos_range;
	logic [CW:0]      mid_sum;
	logic [AW-1:0]    mid;
	logic             search_end;
	logic             full;
	logic [AW-1:0]    ins_slot;
	logic [KEY_W-1:0] bus_key;
	logic [VAL_W-1:0] bus_val;
	logic [VAL_W-1:0] raw_sum;
	logic [VAL_W-1:0] sat_sum;
	logic             ovf;

	logic [1:0]       a_status;
	logic [5:0]       a_slot;
	logic [KEY_W-1:0] a_key;
	logic [VAL_W-1:0] a_val;
	logic [CW-1:0]    a_count;

	assign accept     = start && (state_q == S_IDLE);
	assign pos_range  = {{CW{1'b0}}, position} >= {6'd0, count_q};
	assign mid_sum    = {1'b0, lo_q} + {1'b0, hx_q} - (CW+1)'(1);
	assign mid        = AW'(mid_sum >> 1);
	assign search_end = lo_q >= hx_q;
	assign full       = count_q == CW'(CAPACITY);

	generate
		for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
			logic [KEY_W-1:0] pk;
			logic [VAL_W-1:0] pv;
			logic             plt;
			logic [KEY_W-1:0] nk;
			logic [VAL_W-1:0] nv;
			if (i == 0) begin : g_first
				assign pk  = '0;
				assign pv  = '0;
				assign plt = 1'b1;
			end else begin : g_mid
				assign pk  = cell_key[i-1];
				assign pv  = cell_val[i-1];
				assign plt = lt_vec[i-1];
			end
			if (i == CAPACITY - 1) begin : g_last
				assign nk = '0;
				assign nv = '0;
			end else begin : g_inner
				assign nk = cell_key[i+1];
				assign nv = cell_val[i+1];
			end
			srs_cell #(
				.INDEX(i),
				.AW   (AW),
				.CW   (CW)
			) u_cell (
				.clk       (clk),
				.ctrl      (ctrl),
				.key       (key_q),
				.wdata     (wdata),
				.count     (count_q),
				.idx       (idx_q),
				.prev_key  (pk),
				.prev_value(pv),
				.prev_lt   (plt),
				.next_key  (nk),
				.next_value(nv),
				.cur_key   (cell_key[i]),
				.cur_value (cell_val[i]),
				.lt        (lt_vec[i]),
				.gt        (gt_vec[i]),
				.ins_here  (ins_vec[i]),
				.rd_key    (cell_rk[i]),
				.rd_value  (cell_rv[i])
			);
		end
	endgenerate

	always_comb begin
		bus_key  = '0;
		bus_val  = '0;
		ins_slot = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			bus_key = bus_key | cell_rk[i];
			bus_val = bus_val | cell_rv[i];
			if (ins_vec[i]) begin
				ins_slot = ins_slot | AW'(i);
			end
		end
	end

	assign raw_sum = rd_val_q + val_q;
	assign ovf     = ((rd_val_q[VAL_W-1] ^ raw_sum[VAL_W-1]) &
		(val_q[VAL_W-1] ^ raw_sum[VAL_W-1])) == 1'b1;
	assign sat_sum = !ovf ? raw_sum :
		(rd_val_q[VAL_W-1] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		ctrl     = '0;
		wdata    = val_q;
		a_status = ST_OK;
		a_slot   = '0;
		a_key    = '0;
		a_val    = '0;
		a_count  = count_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					case (srs_cmd_t'(command)) inside
						CMD_INSERT, CMD_REMOVE, CMD_LOOKUP, CMD_ACCUM, CMD_WRITE: begin
							state_d = S_CMP;
						end
						CMD_READ: begin
							state_d = pos_range ? S_APPLY : S_FETCH;
						end
						default: begin
							state_d = S_APPLY;
						end
					endcase
				end
			end
			S_CMP: begin
				ctrl.cmp = 1'b1;
				state_d  = (cmd_q == CMD_INSERT) ? S_APPLY : S_SEARCH;
			end
			S_SEARCH: begin
				if (search_end) begin
					state_d = S_APPLY;
				end else if (!lt_vec[mid] && !gt_vec[mid]) begin
					state_d = S_FETCH;
				end
			end
			S_FETCH: begin
				state_d = S_APPLY;
			end
			S_APPLY: begin
				state_d = S_IDLE;
				case (cmd_q)
					CMD_INSERT: begin
						if (full) begin
							a_status = ST_FULL;
						end else begin
							ctrl.ins = 1'b1;
							a_slot   = 6'(ins_slot);
							a_val    = val_q;
							a_count  = count_q + CW'(1);
						end
					end
					CMD_REMOVE: begin
						if (miss_q) begin
							a_status = ST_MISSING;
						end else begin
							ctrl.rem = 1'b1;
							a_slot   = 6'(idx_q);
							a_val    = rd_val_q;
							a_count  = count_q - CW'(1);
						end
					end
					CMD_LOOKUP: begin
						if (miss_q) begin
							a_status = ST_MISSING;
						end else begin
							a_slot = 6'(idx_q);
							a_val  = rd_val_q;
						end
					end
					CMD_ACCUM: begin
						wdata = sat_sum;
						if (miss_q) begin
							a_status = ST_MISSING;
						end else begin
							ctrl.wr = 1'b1;
							a_slot  = 6'(idx_q);
							a_val   = sat_sum;
						end
					end
					CMD_WRITE: begin
						if (miss_q) begin
							a_status = ST_MISSING;
						end else begin
							ctrl.wr = 1'b1;
							a_slot  = 6'(idx_q);
							a_val   = val_q;
						end
					end
					CMD_READ: begin
						if (miss_q) begin
							a_status = ST_RANGE;
						end else begin
							a_slot = 6'(idx_q);
							a_key  = rd_key_q;
							a_val  = rd_val_q;
						end
					end
					default: begin
						a_status = ST_OK;
					end
				endcase
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= state_q == S_APPLY;
			if (state_q == S_APPLY) begin
				count_q <= a_count;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= srs_cmd_t'(command);
			key_q  <= key;
			val_q  <= value;
			idx_q  <= AW'(position);
			miss_q <= pos_range;
		end
		if (state_q == S_CMP) begin
			lo_q   <= '0;
			hx_q   <= count_q;
			miss_q <= 1'b0;
		end
		if (state_q == S_SEARCH) begin
			if (search_end) begin
				miss_q <= 1'b1;
			end else if (lt_vec[mid]) begin
				lo_q <= mid_sum[CW:1] + CW'(1);
			end else if (gt_vec[mid]) begin
				hx_q <= mid_sum[CW:1];
			end else begin
				idx_q <= mid;
			end
		end
		if (state_q == S_FETCH) begin
			rd_key_q <= bus_key;
			rd_val_q <= bus_val;
		end
		if (state_q == S_APPLY) begin
			status_q    <= a_status;
			slot_q      <= a_slot;
			key_out_q   <= a_key;
			value_out_q <= a_val;
		end
	end

	assign busy        = state_q != S_IDLE;
	assign done        = done_q;
	assign status      = status_q;
	assign slot        = slot_q;
	assign key_out     = key_out_q;
	assign value_out   = value_out_q;
	assign entry_total = 7'(count_q);

endmodule

[tb/sorted_key_value_row_store_test.sv]
// Self-checking testbench for sorted_key_value_row_store: directed and random command
// streams, each result checked against a shadow copy of the sorted row.
// Depends on srs_pkg and the design files of the row store.
`timescale 1ns / 1ps

import srs_pkg::*;

typedef struct {
	srs_status_t             status;
	logic [5:0]              slot;
	logic [KEY_W-1:0]        key;
	logic signed [VAL_W-1:0] value;
	logic [6:0]              total;
} row_result_t;

class row_shadow;
	logic [KEY_W-1:0]        keys[CAPACITY_DEF];
	logic signed [VAL_W-1:0] vals[CAPACITY_DEF];
	int unsigned             count;
	int unsigned             errors;
	row_result_t             pending_results[$];

	function new();
		count = 0;
		errors = 0;
	endfunction

	function int find_key(logic [KEY_W-1:0] k);
		int lo;
		int hi;
		int mid;
		lo = 0;
		hi = int'(count) - 1;
		while (lo <= hi) begin
			mid = (lo + hi) / 2;
			if (keys[mid] < k)
				lo = mid + 1;
			else if (keys[mid] > k)
				hi = mid - 1;
			else
				return mid;
		end
		return -1;
	endfunction

	function void note_command(srs_cmd_t cmd, logic [KEY_W-1:0] k,
		logic signed [VAL_W-1:0] v, logic [5:0] pos);
		row_result_t r;
		int idx;
		int unsigned p;
		logic signed [VAL_W-1:0] sum;
		r = '{ST_OK, 6'd0, 32'd0, 64'sd0, 7'd0};
		case (cmd)
		CMD_INSERT: begin
			if (count >= CAPACITY_DEF) begin
				r.status = ST_FULL;
			end else begin
				p = 0;
				while (p < count && keys[p] < k)
					p++;
				for (int j = int'(count); j > int'(p); j--) begin
					keys[j] = keys[j - 1];
					vals[j] = vals[j - 1];
				end
				keys[p] = k;
				vals[p] = v;
				count++;
				r.slot = p[5:0];
				r.value = v;
			end
		end
		CMD_REMOVE: begin
			idx = find_key(k);
			if (idx < 0) begin
				r.status = ST_MISSING;
			end else begin
				r.value = vals[idx];
				for (int j = idx; j + 1 < int'(count); j++) begin
					keys[j] = keys[j + 1];
					vals[j] = vals[j + 1];
				end
				count--;
				r.slot = idx[5:0];
			end
		end
		CMD_LOOKUP, CMD_ACCUM, CMD_WRITE: begin
			idx = find_key(k);
			if (idx < 0) begin
				r.status = ST_MISSING;
			end else begin
				if (cmd == CMD_ACCUM) begin
					sum = vals[idx] + v;
					// saturate on signed overflow
					if (vals[idx][VAL_W-1] == v[VAL_W-1] && sum[VAL_W-1] != v[VAL_W-1])
						sum = v[VAL_W-1] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
					vals[idx] = sum;
				end else if (cmd == CMD_WRITE) begin
					vals[idx] = v;
				end
				r.value = vals[idx];
				r.slot = idx[5:0];
			end
		end
		CMD_READ: begin
			if (pos >= count) begin
				r.status = ST_RANGE;
			end else begin
				r.slot = pos;
				r.key = keys[pos];
				r.value = vals[pos];
			end
		end
		default: ;
		endcase
		r.total = count[6:0];
		pending_results.push_back(r);
	endfunction

	function void check_result(logic [1:0] status, logic [5:0] slot, logic [KEY_W-1:0] key_out,
		logic signed [VAL_W-1:0] value_out, logic [6:0] total);
		row_result_t e;
		if (pending_results.size() == 0) begin
			$display("%0t: unexpected result: status %0d slot %0d key %h value %h total %0d",
				$time, status, slot, key_out, value_out, total);
			errors++;
			return;
		end
		e = pending_results.pop_front();
		if (status !== e.status) begin
			$display("%0t: status mismatch: expected %0d, actual %0d", $time, e.status, status);
			errors++;
		end
		if (slot !== e.slot) begin
			$display("%0t: slot mismatch: expected %0d, actual %0d", $time, e.slot, slot);
			errors++;
		end
		if (key_out !== e.key) begin
			$display("%0t: key_out mismatch: expected %h, actual %h", $time, e.key, key_out);
			errors++;
		end
		if (value_out !== e.value) begin
			$display("%0t: value_out mismatch: expected %h, actual %h", $time, e.value, value_out);
			errors++;
		end
		if (total !== e.total) begin
			$display("%0t: entry_total mismatch: expected %0d, actual %0d", $time, e.total, total);
			errors++;
		end
	endfunction
endclass

module sorted_key_value_row_store_test;
	localparam logic signed [VAL_W-1:0] Q_MAX = {1'b0, {(VAL_W-1){1'b1}}};
	localparam logic signed [VAL_W-1:0] Q_MIN = {1'b1, {(VAL_W-1){1'b0}}};
	localparam int RANDOM_ITEMS = 550;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    start = 1'b0;
	logic [2:0]              command = 3'd0;
	logic [KEY_W-1:0]        key = '0;
	logic signed [VAL_W-1:0] value = '0;
	logic [5:0]              position = '0;
	logic                    busy;
	logic                    done;
	logic [1:0]              status;
	logic [5:0]              slot;
	logic [KEY_W-1:0]        key_out;
	logic signed [VAL_W-1:0] value_out;
	logic [6:0]              entry_total;

	row_shadow shadow = new();

	sorted_key_value_row_store #(
		.CAPACITY(CAPACITY_DEF)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.command(command),
		.key(key),
		.value(value),
		.position(position),
		.done(done),
		.status(status),
		.slot(slot),
		.key_out(key_out),
		.value_out(value_out),
		.entry_total(entry_total)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && done)
			shadow.check_result(status, slot, key_out, value_out, entry_total);
	end

	task automatic issue(srs_cmd_t cmd, logic [KEY_W-1:0] k, logic signed [VAL_W-1:0] v,
		logic [5:0] pos);
		start <= 1'b1;
		command <= cmd;
		key <= k;
		value <= v;
		position <= pos;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		shadow.note_command(cmd, k, v, pos);
	endtask

	task automatic hold_off(int unsigned cycles);
		if (cycles != 0) begin
			start <= 1'b0;
			repeat (cycles) @(posedge clk);
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (shadow.pending_results.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		srs_cmd_t cmd;
		logic [KEY_W-1:0] k;
		logic signed [VAL_W-1:0] v;
		logic [5:0] pos;
		int unsigned roll;
		int unsigned burst;
		bit grow;
		bit quiet;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty row
		issue(CMD_LOOKUP, 32'd5, 64'sd0, 6'd0);
		issue(CMD_REMOVE, 32'd5, 64'sd0, 6'd0);
		issue(CMD_READ, 32'd0, 64'sd0, 6'd0);
		issue(CMD_ACCUM, 32'd5, 64'sd1, 6'd0);
		issue(CMD_WRITE, 32'd5, 64'sd1, 6'd0);
		// extremes, duplicate keys, saturation
		issue(CMD_INSERT, 32'd0, Q_MAX, 6'd0);
		issue(CMD_INSERT, '1, Q_MIN, 6'd63);
		issue(CMD_INSERT, 32'd100, 64'sd1, 6'd0);
		issue(CMD_INSERT, 32'd100, 64'sd2, 6'd0);
		issue(CMD_LOOKUP, 32'd100, 64'sd0, 6'd0);
		issue(CMD_ACCUM, 32'd0, Q_MAX, 6'd0);
		issue(CMD_ACCUM, '1, Q_MIN, 6'd0);
		issue(CMD_ACCUM, 32'd100, '1, 6'd0);
		issue(CMD_WRITE, 32'd100, 64'sh0000_0001_8000_0000, 6'd0);
		for (int i = 0; i < 4; i++)
			issue(CMD_READ, 32'd0, 64'sd0, i[5:0]);
		issue(CMD_READ, 32'd0, 64'sd0, 6'd4);
		issue(CMD_READ, '1, Q_MIN, 6'd63);
		issue(CMD_REMOVE, 32'd100, 64'sd0, 6'd0);
		issue(CMD_REMOVE, 32'd0, 64'sd0, 6'd0);
		issue(CMD_NOP6, '1, '1, '1);
		issue(CMD_NOP7, 32'h1234_5678, Q_MAX, 6'd17);
		drain();

		burst = 0;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			grow = ((n / 80) % 2) == 0;
			quiet = ((n / 120) % 3) == 1;
			if (n == RANDOM_ITEMS / 2)
				drain();
			if (burst == 0) begin
				burst = $urandom_range(1, 16);
				hold_off(quiet ? 0 : $urandom_range(1, 8));
			end

			roll = $urandom_range(0, 99);
			if (roll < 4) begin
				cmd = (roll < 2) ? CMD_NOP6 : CMD_NOP7;
			end else if (roll < (grow ? 80 : 20)) begin
				cmd = CMD_INSERT;
			end else if (roll < (grow ? 86 : 65)) begin
				cmd = CMD_REMOVE;
			end else begin
				case ($urandom_range(0, 3))
				0: cmd = CMD_LOOKUP;
				1: cmd = CMD_ACCUM;
				2: cmd = CMD_WRITE;
				default: cmd = CMD_READ;
				endcase
			end

			if (cmd != CMD_INSERT && shadow.count != 0 && $urandom_range(0, 99) < 70) begin
				k = shadow.keys[$urandom_range(0, shadow.count - 1)];
			end else begin
				case ($urandom_range(0, 9))
				0, 1, 2, 3: k = $urandom_range(0, 15);
				4: k = '1;
				5: k = '0;
				default: k = $urandom;
				endcase
			end

			case ($urandom_range(0, 7))
			0: v = Q_MAX;
			1: v = Q_MIN;
			2: v = '0;
			3: v = '1;
			4: v = {32'd0, $urandom};
			default: v = {$urandom, $urandom};
			endcase

			if (shadow.count != 0 && $urandom_range(0, 1))
				pos = 6'($urandom_range(0, shadow.count - 1));
			else
				pos = 6'($urandom_range(0, 63));

			issue(cmd, k, v, pos);
			burst--;
		end

		start <= 1'b0;
		while (shadow.pending_results.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);

		if (shadow.errors == 0 && shadow.pending_results.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Simulation FAILED");
		$finish;
	end
endmodule
